/* rtl/sha256sb_pkg.sv */
// ----------------------------------------------------------------------------
// sha256sb_pkg
// Shared types and constants for the single-block SHA-256 hash unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sha256sb_pkg;

	// Largest message that fits one padded block
	localparam int unsigned MAX_BYTES = 55;

	// First padding byte after the message
	localparam logic [7:0] PAD_MARK = 8'h80;

	// Request: one message byte
	typedef struct packed {
		logic [7:0] msg_byte;
		logic       final_byte;
	} msg_req_t;

	// Result: one digest word
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        last_word;
		logic        too_long;
	} dig_rsp_t;

	// Round variables a..h, element 0 is a
	typedef logic [7:0][31:0] vars_t;

	// Initial hash values H0..H7
	localparam logic [31:0] H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Round constants K0..K63
	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

`default_nettype wire

/* rtl/sha256sb_round.sv */
// ----------------------------------------------------------------------------
// sha256sb_round
// One SHA-256 compression round plus the next message schedule word.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256sb_round
	import sha256sb_pkg::*;
(
	input  vars_t       v,
	input  logic [31:0] k,
	input  logic [31:0] w0,
	input  logic [31:0] w1,
	input  logic [31:0] w9,
	input  logic [31:0] w14,
	output vars_t       v_next,
	output logic [31:0] w_new
);

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] t1;
	logic [31:0] t2;

	// Compute the round terms
	assign ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
	assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
	assign t1  = v[7] + big_sigma1(v[4]) + ch + k + w0;
	assign t2  = big_sigma0(v[0]) + maj;

	// Rotate the working variables
	assign v_next[0] = t1 + t2;
	assign v_next[1] = v[0];
	assign v_next[2] = v[1];
	assign v_next[3] = v[2];
	assign v_next[4] = v[3] + t1;
	assign v_next[5] = v[4];
	assign v_next[6] = v[5];
	assign v_next[7] = v[6];

	// Extend the schedule sixteen words ahead
	assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

endmodule

`default_nettype wire

/* rtl/sha256_single_block_hash_unit.sv */
// ----------------------------------------------------------------------------
// sha256_single_block_hash_unit
// Single-block SHA-256: gathers bytes, pads, hashes, streams eight words.
// ----------------------------------------------------------------------------
// A message of n bytes (1 to 55) is taken one byte a cycle; after the final
// byte the unit stalls its input while it pads (one schedule word per cycle),
// compresses (one round per cycle through a single round unit) and hands out
// the digest words H0 to H7. A message longer than 55 bytes skips padding and
// rounds: its eight words are zero with too_long set. The last digest word
// may still wait in the output register while the next message is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_single_block_hash_unit
	import sha256sb_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  wire      msg_valid,
	output logic     msg_stall,
	input  msg_req_t msg,
	output logic     dig_valid,
	input  wire      dig_stall,
	output dig_rsp_t dig
);

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_PAD,
		ST_ROUND,
		ST_EMIT
	} state_t;

	state_t      state_q;
	logic [5:0]  cnt_q;
	logic [5:0]  count_q;
	logic        ovf_q;
	logic        dig_valid_q;
	dig_rsp_t    dig_q;

	logic [31:0] w_q [16];
	vars_t       v_q;

	logic        msg_acc;
	logic        full;
	logic        ovf_now;
	logic        out_free;
	logic [3:0]  pad_idx;
	logic [5:0]  pad_pos;
	logic [31:0] pad_cur;
	logic [31:0] pad_word;
	logic [2:0]  emit_idx;
	logic [31:0] emit_word;
	vars_t       v_next;
	logic [31:0] w_new;

	// Handshake decode
	assign msg_stall = (state_q != ST_COLLECT);
	assign msg_acc   = msg_valid & ~msg_stall;
	assign full      = (count_q == 6'(MAX_BYTES));
	assign ovf_now   = ovf_q | full;
	assign out_free  = ~dig_valid_q | ~dig_stall;
	assign dig_valid = dig_valid_q;
	assign dig       = dig_q;

	// Build one padded schedule word: keep message bytes, mark, zeros, length
	assign pad_idx = cnt_q[3:0];
	assign pad_cur = w_q[pad_idx];

	always_comb begin
		pad_word = '0;
		pad_pos  = '0;
		for (int l = 0; l < 4; l++) begin
			pad_pos = {pad_idx, 2'(l)};
			if (pad_pos < count_q) begin
				pad_word[8*(3-l) +: 8] = pad_cur[8*(3-l) +: 8];
			end else if (pad_pos == count_q) begin
				pad_word[8*(3-l) +: 8] = PAD_MARK;
			end
		end
		if (pad_idx == 4'd15) begin
			pad_word[15:0] = {7'd0, count_q, 3'b000};
		end
	end

	// Shared round unit
	sha256sb_round u_round (
		.v      (v_q),
		.k      (ROUND_K[cnt_q]),
		.w0     (w_q[0]),
		.w1     (w_q[1]),
		.w9     (w_q[9]),
		.w14    (w_q[14]),
		.v_next (v_next),
		.w_new  (w_new)
	);

	// Final digest word: initial value plus working variable, or zero if overlong
	assign emit_idx  = cnt_q[2:0];
	assign emit_word = ovf_q ? 32'd0 : (H_INIT[emit_idx] + v_q[emit_idx]);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_COLLECT;
			cnt_q       <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			dig_valid_q <= 1'b0;
			dig_q       <= '0;
		end else begin
			// Raise valid on a fresh word, drop it once the word is taken
			if (state_q == ST_EMIT && out_free) begin
				dig_valid_q <= 1'b1;
			end else if (dig_valid_q && !dig_stall) begin
				dig_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_COLLECT: begin
					if (msg_acc) begin
						if (!full) begin
							count_q <= count_q + 6'd1;
						end
						ovf_q <= ovf_now;
						cnt_q <= '0;
						if (msg.final_byte) begin
							state_q <= ovf_now ? ST_EMIT : ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (pad_idx == 4'd15) begin
						cnt_q   <= '0;
						state_q <= ST_ROUND;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_ROUND: begin
					if (cnt_q == 6'd63) begin
						cnt_q   <= '0;
						state_q <= ST_EMIT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						dig_q.digest_word <= emit_word;
						dig_q.word_number <= emit_idx;
						dig_q.last_word   <= (emit_idx == 3'd7);
						dig_q.too_long    <= ovf_q;
						if (emit_idx == 3'd7) begin
							cnt_q   <= '0;
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= ST_COLLECT;
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	// Message store, schedule window and working variables
	always_ff @(posedge clk) begin
		if (msg_acc && !full) begin
			w_q[count_q[5:2]][{~count_q[1:0], 3'b000} +: 8] <= msg.msg_byte;
		end
		if (state_q == ST_PAD) begin
			w_q[pad_idx] <= pad_word;
			if (pad_idx == 4'd15) begin
				for (int i = 0; i < 8; i++) begin
					v_q[i] <= H_INIT[i];
				end
			end
		end
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[15] <= w_new;
			v_q     <= v_next;
		end
	end

endmodule

`default_nettype wire

/* rtl/sha256sb_checker.sv */
// ----------------------------------------------------------------------------
// sha256sb_checker
// Port-level checks for the single-block SHA-256 hash unit.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256sb_checker
	import sha256sb_pkg::*;
(
	input wire      clk,
	input wire      arst_n,
	input wire      msg_valid,
	input wire      msg_stall,
	input msg_req_t msg,
	input wire      dig_valid,
	input wire      dig_stall,
	input dig_rsp_t dig
);

	// Hold a stalled result
	a_dig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_stall |=> dig_valid && $stable(dig))
		else $error("stalled digest word changed");

	// Stop taking bytes once a final byte is in
	a_final_busy: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_stall && msg.final_byte |=> msg_stall)
		else $error("byte request taken right after a final byte");

	// Flag the eighth word and only it
	a_last_word: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (dig.last_word == (dig.word_number == 3'd7)))
		else $error("last_word does not match word_number");

	// Zero the words of an overlong message
	a_too_long: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig.too_long |-> (dig.digest_word == 32'd0))
		else $error("overlong message gave a nonzero word");

	// Stay busy while more than one digest word remains
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_stall && !dig.last_word && (dig.word_number != 3'd6)
		|=> msg_stall)
		else $error("byte request taken before digest was handed out");

endmodule

bind sha256_single_block_hash_unit sha256sb_checker u_checker (.*);

`default_nettype wire
